// ===== hdl/cau_pkg.sv =====
// Shared types, codes and helpers for the complex arithmetic unit.
`timescale 1ns / 1ps
`default_nettype none
package cau_pkg;

   // Quotient bits produced by the divider, one per stage
   localparam int QW = 32;

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK  = 2'd0,
      ST_OVF = 2'd1,
      ST_DZ  = 2'd2
   } status_type;

   // Registered products of the multiplier stage
   typedef struct packed {
      logic signed [63:0] p_rr;   // a_re * b_re
      logic signed [63:0] p_ii;   // a_im * b_im
      logic signed [63:0] p_ri;   // a_re * b_im
      logic signed [63:0] p_ir;   // a_im * b_re
      logic signed [63:0] p_bb;   // b_re * b_re
      logic signed [63:0] p_cc;   // b_im * b_im
   } prod_type;

   // One quotient lane of the restoring divider
   typedef struct packed {
      logic          neg;   // numerator sign
      logic          qovf;  // quotient at least 2^QW
      logic [64:0]   rem;   // partial remainder, below den
      logic [QW-1:0] dlo;   // dividend bits not yet shifted in
      logic [QW-1:0] q;     // quotient bits so far
   } lane_type;

   // Payload traveling down the divider stages
   typedef struct packed {
      op_type             op;
      logic               dz;       // zero divisor
      logic signed [64:0] dir_re;   // add/sub/mul result, before saturation
      logic signed [64:0] dir_im;
      logic [63:0]        den;
      lane_type           re;
      lane_type           im;
   } div_type;

   localparam logic signed [64:0] SAT_HI = 65'sd2147483647;
   localparam logic signed [64:0] SAT_LO = -65'sd2147483648;

   // Clamp to 32-bit signed; bit 32 flags saturation
   function automatic logic [32:0] sat32(input logic signed [64:0] x);
      logic [32:0] r;
      if (x > SAT_HI) begin
         r = {1'b1, 32'h7FFF_FFFF};
      end else if (x < SAT_LO) begin
         r = {1'b1, 32'h8000_0000};
      end else begin
         r = {1'b0, x[31:0]};
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== hdl/complex_arithmetic_unit.sv =====
// Complex add/subtract/multiply/divide on Q-format operands, fully pipelined.
// Throughput: one transaction per cycle unless the output stalls; the 32 divider
// stages each retire one quotient bit for every item, so all opcodes share the same
// path and rate. Empty stages fill in while the output waits, so input is taken
// until full. Reset (synchronous, active high) clears all stage valid bits;
// no data reset.
`timescale 1ns / 1ps
`default_nettype none
module complex_arithmetic_unit
   import cau_pkg::*;
#(
   parameter int FRAC_BITS = 16
)
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [127:0] req_tdata,  // a_re, a_im, b_re, b_im
   input  wire logic [1:0]   req_tuser,  // opcode
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [63:0]       rsp_tdata,  // res_re, res_im
   output logic [1:0]        rsp_tuser   // status
);

   localparam int NS  = QW + 5;        // input, mult, combine, prep, divider, output
   localparam int DVS = 4;             // first divider stage
   localparam int DW  = 64 + FRAC_BITS;

   logic [NS-1:0] v_ff;
   logic [NS-1:0] rdy;

   // stage ready: a stage loads when empty or when the next one loads
   always_comb begin
      rdy[NS-1] = !v_ff[NS-1] || rsp_tready;
      for (int i = NS - 2; i >= 0; i--) begin
         rdy[i] = !v_ff[i] || rdy[i+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (rdy[0]) begin
            v_ff[0] <= req_tvalid;
         end
         for (int i = 1; i < NS; i++) begin
            if (rdy[i]) begin
               v_ff[i] <= v_ff[i-1];
            end
         end
      end
   end

   assign req_tready = rdy[0];

   // stage 0: input register
   op_type             op0_ff;
   logic signed [31:0] are0_ff, aim0_ff, bre0_ff, bim0_ff;

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         op0_ff  <= op_type'(req_tuser);
         are0_ff <= req_tdata[31:0];
         aim0_ff <= req_tdata[63:32];
         bre0_ff <= req_tdata[95:64];
         bim0_ff <= req_tdata[127:96];
      end
   end

   // stage 1: products, plus the add/subtract result
   prod_type           prod;
   op_type             op1_ff;
   logic signed [32:0] sum_re1_ff, sum_im1_ff;

   cau_mult u_mult (
      .clock (clock),
      .load  (rdy[1]),
      .a_re  (are0_ff),
      .a_im  (aim0_ff),
      .b_re  (bre0_ff),
      .b_im  (bim0_ff),
      .prod  (prod)
   );

   always_ff @(posedge clock) begin
      if (rdy[1]) begin
         op1_ff <= op0_ff;
         if (op0_ff == OP_SUB) begin
            sum_re1_ff <= 33'(are0_ff) - 33'(bre0_ff);
            sum_im1_ff <= 33'(aim0_ff) - 33'(bim0_ff);
         end else begin
            sum_re1_ff <= 33'(are0_ff) + 33'(bre0_ff);
            sum_im1_ff <= 33'(aim0_ff) + 33'(bim0_ff);
         end
      end
   end

   // stage 2: sums of products, divisor, direct result selection
   op_type             op2_ff;
   logic signed [64:0] dir_re2_ff, dir_im2_ff, nre2_ff, nim2_ff;
   logic [63:0]        den2_ff;
   logic signed [64:0] mre, mim;

   always_comb begin
      mre = 65'($signed(prod.p_rr)) - 65'($signed(prod.p_ii));
      mim = 65'($signed(prod.p_ri)) + 65'($signed(prod.p_ir));
   end

   always_ff @(posedge clock) begin
      if (rdy[2]) begin
         op2_ff  <= op1_ff;
         nre2_ff <= 65'($signed(prod.p_rr)) + 65'($signed(prod.p_ii));
         nim2_ff <= 65'($signed(prod.p_ir)) - 65'($signed(prod.p_ri));
         den2_ff <= 64'(prod.p_bb) + 64'(prod.p_cc);
         if (op1_ff == OP_MUL) begin
            dir_re2_ff <= mre >>> FRAC_BITS;
            dir_im2_ff <= mim >>> FRAC_BITS;
         end else begin
            dir_re2_ff <= 65'(sum_re1_ff);
            dir_im2_ff <= 65'(sum_im1_ff);
         end
      end
   end

   // stage 3: divider setup, scaled dividend and high-quotient check
   function automatic lane_type prep(input logic signed [64:0] n, input logic [63:0] den);
      lane_type    l;
      logic [63:0] mag;
      logic [DW-1:0] d;
      logic [64:0] hi;
      mag    = (n < 0) ? 64'(-n) : 64'(n);
      d      = DW'(mag) << FRAC_BITS;
      hi     = 65'(d >> QW);
      l.neg  = (n < 0);
      l.qovf = (hi >= {1'b0, den});
      l.rem  = l.qovf ? '0 : hi;
      l.dlo  = d[QW-1:0];
      l.q    = '0;
      return l;
   endfunction

   div_type prp_ff;

   always_ff @(posedge clock) begin
      if (rdy[3]) begin
         prp_ff.op     <= op2_ff;
         prp_ff.dz     <= (den2_ff == '0);
         prp_ff.dir_re <= dir_re2_ff;
         prp_ff.dir_im <= dir_im2_ff;
         prp_ff.den    <= den2_ff;
         prp_ff.re     <= prep(nre2_ff, den2_ff);
         prp_ff.im     <= prep(nim2_ff, den2_ff);
      end
   end

   // stages 4..QW+3: one quotient bit per stage
   div_type dv [QW];

   for (genvar k = 0; k < QW; k++) begin : g_div
      if (k == 0) begin : g_first
         cau_div_step u_step (
            .clock (clock),
            .load  (rdy[DVS]),
            .din   (prp_ff),
            .dout  (dv[0])
         );
      end else begin : g_next
         cau_div_step u_step (
            .clock (clock),
            .load  (rdy[DVS+k]),
            .din   (dv[k-1]),
            .dout  (dv[k])
         );
      end
   end

   // output stage: signed quotient, saturation, status
   function automatic logic signed [64:0] qval(input lane_type l);
      logic [33:0] m;
      m = l.qovf ? 34'h2_0000_0000 : {2'b00, l.q};
      return l.neg ? -65'(m) : 65'(m);
   endfunction

   div_type            dfin;
   logic signed [64:0] fre, fim;
   logic [32:0]        sre, sim;
   logic [31:0]        res_re_ff, res_im_ff;
   status_type         status_ff;

   always_comb begin
      dfin = dv[QW-1];
      if (dfin.op == OP_DIV) begin
         fre = qval(dfin.re);
         fim = qval(dfin.im);
      end else begin
         fre = dfin.dir_re;
         fim = dfin.dir_im;
      end
      sre = sat32(fre);
      sim = sat32(fim);
   end

   always_ff @(posedge clock) begin
      if (rdy[NS-1]) begin
         if (dfin.op == OP_DIV && dfin.dz) begin
            res_re_ff <= '0;
            res_im_ff <= '0;
            status_ff <= ST_DZ;
         end else begin
            res_re_ff <= sre[31:0];
            res_im_ff <= sim[31:0];
            status_ff <= (sre[32] || sim[32]) ? ST_OVF : ST_OK;
         end
      end
   end

   assign rsp_tvalid = v_ff[NS-1];
   assign rsp_tdata  = {res_im_ff, res_re_ff};
   assign rsp_tuser  = status_ff;

   // divide-by-zero results carry zero parts
   a_dz_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && status_ff == ST_DZ |-> res_re_ff == '0 && res_im_ff == '0)
      else $error("divide-by-zero result not zero");

   // overflow status implies a part sits on a rail
   a_ovf_rail: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && status_ff == ST_OVF |->
         res_re_ff == 32'h7FFF_FFFF || res_re_ff == 32'h8000_0000 ||
         res_im_ff == 32'h7FFF_FFFF || res_im_ff == 32'h8000_0000)
      else $error("overflow status without saturated part");

   // an empty output stage means the whole pipe can take input
   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with empty output");

   // an accepted transaction occupies the first stage next cycle
   a_fill: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> v_ff[0])
      else $error("accepted transaction lost at entry");

endmodule
`default_nettype wire

// ===== hdl/cau_mult.sv =====
// Multiplier stage: six registered 32x32 signed products.
`timescale 1ns / 1ps
`default_nettype none
module cau_mult
   import cau_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               load,
   input  wire logic signed [31:0] a_re,
   input  wire logic signed [31:0] a_im,
   input  wire logic signed [31:0] b_re,
   input  wire logic signed [31:0] b_im,
   output prod_type                prod
);

   prod_type prod_ff;

   // cross products for multiply/divide numerators, squares for the divisor
   always_ff @(posedge clock) begin
      if (load) begin
         prod_ff.p_rr <= a_re * b_re;
         prod_ff.p_ii <= a_im * b_im;
         prod_ff.p_ri <= a_re * b_im;
         prod_ff.p_ir <= a_im * b_re;
         prod_ff.p_bb <= b_re * b_re;
         prod_ff.p_cc <= b_im * b_im;
      end
   end

   assign prod = prod_ff;

endmodule
`default_nettype wire

// ===== hdl/cau_div_step.sv =====
// One restoring-division step for both quotient lanes, registered.
`timescale 1ns / 1ps
`default_nettype none
module cau_div_step
   import cau_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    load,
   input  wire div_type din,
   output div_type      dout
);

   div_type dout_ff;
   div_type dout_in;

   function automatic lane_type step(input lane_type l, input logic [63:0] den);
      lane_type   r;
      logic [64:0] r2;
      logic        ge;
      r2 = {l.rem[63:0], l.dlo[QW-1]};
      ge = (r2 >= {1'b0, den});
      r  = l;
      r.rem = ge ? (r2 - {1'b0, den}) : r2;
      r.q   = {l.q[QW-2:0], ge};
      r.dlo = {l.dlo[QW-2:0], 1'b0};
      return r;
   endfunction

   // shift in one dividend bit, trial-subtract the divisor
   always_comb begin
      dout_in    = din;
      dout_in.re = step(din.re, din.den);
      dout_in.im = step(din.im, din.den);
   end

   always_ff @(posedge clock) begin
      if (load) begin
         dout_ff <= dout_in;
      end
   end

   assign dout = dout_ff;

endmodule
`default_nettype wire

// ===== test/complex_arithmetic_unit_tb.sv =====
// Self-checking testbench for the complex arithmetic unit: directed, random, stalls.
`timescale 1ns / 1ps
`default_nettype none

// Holds the complex results still owed by the block, oldest first
class cplx_scoreboard;
   logic [31:0] want_re[$];
   logic [31:0] want_im[$];
   cau_pkg::status_type want_st[$];
   int errors = 0;
   int checked = 0;

   // Note one accepted operand transaction and queue its expected result
   function void note_operation(cau_pkg::op_type op, logic signed [31:0] ar,
                                logic signed [31:0] ai, logic signed [31:0] br,
                                logic signed [31:0] bi);
      logic signed [127:0] re, im, den, q;
      logic signed [127:0] nums[2];
      logic ovf;
      cau_pkg::status_type st;
      logic [31:0] ore, oim;
      ovf = 1'b0;
      st = cau_pkg::ST_OK;
      re = 0;
      im = 0;
      case (op)
         cau_pkg::OP_ADD: begin
            re = 128'(ar) + 128'(br);
            im = 128'(ai) + 128'(bi);
         end
         cau_pkg::OP_SUB: begin
            re = 128'(ar) - 128'(br);
            im = 128'(ai) - 128'(bi);
         end
         cau_pkg::OP_MUL: begin
            re = (128'(ar) * 128'(br) - 128'(ai) * 128'(bi)) >>> 16;
            im = (128'(ar) * 128'(bi) + 128'(ai) * 128'(br)) >>> 16;
         end
         default: begin
            den = 128'(br) * 128'(br) + 128'(bi) * 128'(bi);
            if (den == 0) begin
               st = cau_pkg::ST_DZ;
            end else begin
               nums[0] = 128'(ar) * 128'(br) + 128'(ai) * 128'(bi);
               nums[1] = 128'(ai) * 128'(br) - 128'(ar) * 128'(bi);
               // signed divide truncates toward zero
               for (int k = 0; k < 2; k++) begin
                  q = (nums[k] <<< 16) / den;
                  if (k == 0) re = q; else im = q;
               end
            end
         end
      endcase
      ore = 32'(re);
      oim = 32'(im);
      if (re > 128'sh7FFF_FFFF) begin ore = 32'h7FFF_FFFF; ovf = 1'b1; end
      if (re < -128'sh8000_0000) begin ore = 32'h8000_0000; ovf = 1'b1; end
      if (im > 128'sh7FFF_FFFF) begin oim = 32'h7FFF_FFFF; ovf = 1'b1; end
      if (im < -128'sh8000_0000) begin oim = 32'h8000_0000; ovf = 1'b1; end
      if (st == cau_pkg::ST_DZ) begin
         ore = 0;
         oim = 0;
      end else if (ovf) begin
         st = cau_pkg::ST_OVF;
      end
      want_re.push_back(ore);
      want_im.push_back(oim);
      want_st.push_back(st);
   endfunction

   // Compare one result transaction with the oldest expectation
   function void check_result(logic [31:0] re, logic [31:0] im, logic [1:0] st);
      if (want_st.size() == 0) begin
         $error("unexpected result re=%h im=%h status=%0d", re, im, st);
         errors++;
         return;
      end
      checked++;
      if (re !== want_re[0]) begin
         $error("res_re expected %h actual %h", want_re[0], re);
         errors++;
      end
      if (im !== want_im[0]) begin
         $error("res_im expected %h actual %h", want_im[0], im);
         errors++;
      end
      if (st !== want_st[0]) begin
         $error("status expected %0d actual %0d", want_st[0], st);
         errors++;
      end
      void'(want_re.pop_front());
      void'(want_im.pop_front());
      void'(want_st.pop_front());
   endfunction

   function int pending();
      return want_st.size();
   endfunction
endclass

module complex_arithmetic_unit_tb;
   import cau_pkg::*;

   localparam int LATENCY = 37;
   localparam int CYCLE_LIMIT = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [127:0] req_tdata = '0;  // a_re, a_im, b_re, b_im
   logic [1:0] req_tuser = '0;    // opcode
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;        // res_re, res_im
   logic [1:0] rsp_tuser;         // status

   cplx_scoreboard board = new();
   int cycles = 0;
   int sent = 0;
   int n_ovf = 0;
   int n_dz = 0;
   bit hold_sink = 1'b0;

   complex_arithmetic_unit uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   always #5 clock = ~clock;

   // Watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Record accepted operands
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         board.note_operation(op_type'(req_tuser), req_tdata[31:0], req_tdata[63:32],
                              req_tdata[95:64], req_tdata[127:96]);
      end
   end

   // Check results
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         board.check_result(rsp_tdata[31:0], rsp_tdata[63:32], rsp_tuser);
         if (rsp_tuser == ST_OVF) n_ovf++;
         if (rsp_tuser == ST_DZ) n_dz++;
      end
   end

   // Sink backpressure: random stalls, steady-ready stretches, or a long hold when asked
   always @(posedge clock) begin
      if (hold_sink) begin
         rsp_tready <= 1'b0;
      end else if ($urandom_range(0, 99) < 70 || (cycles / 2000) % 3 == 2) begin
         rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= 1'b0;
      end
   end

   // Long receiver hold counted in its own process
   initial begin
      wait (sent >= 60);
      @(posedge clock);
      hold_sink = 1'b1;
      repeat (300) @(posedge clock);
      hold_sink = 1'b0;
   end

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 9))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return 32'h0;
         3: return 32'(signed'($urandom_range(0, 32'h1_FFFF)) - 65536);
         4, 5: return 32'(signed'($urandom_range(0, 32'h7F_FFFF)) - 32'sh400000);
         default: return $urandom();
      endcase
   endfunction

   // Offer one transaction, after optional random gaps, and wait for it to be taken
   task automatic send_op(op_type op, logic [31:0] ar, logic [31:0] ai,
                          logic [31:0] br, logic [31:0] bi, bit gaps);
      int gap;
      if (gaps) begin
         gap = ($urandom_range(0, 19) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
         if ((sent / 150) % 3 == 1) gap = 0;
         repeat (gap) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {bi, br, ai, ar};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent++;
   endtask

   // advance the clock first so the last accepted transaction is already noted
   task automatic drain();
      @(posedge clock);
      while (board.pending() > 0) @(posedge clock);
   endtask

   initial begin
      logic [31:0] ext[4];
      ext = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF};
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: extremes per opcode, zero divisor, overflow cases
      for (int o = 0; o < 4; o++) begin
         send_op(op_type'(o), ext[0], ext[1], ext[0], ext[1], 1'b0);
         send_op(op_type'(o), ext[1], ext[1], ext[1], ext[1], 1'b0);
         send_op(op_type'(o), 32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
                 32'hFFFF_0000, 1'b0);
         send_op(op_type'(o), ext[3], ext[0], 32'h0000_0001, ext[3], 1'b0);
      end
      send_op(OP_DIV, ext[0], ext[1], 32'h0, 32'h0, 1'b0);
      send_op(OP_DIV, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0);
      send_op(OP_DIV, ext[0], ext[0], 32'h0000_0001, 32'h0, 1'b0);
      send_op(OP_DIV, 32'hFFFF_FFFF, 32'h0, 32'h0003_0000, 32'h0, 1'b0);
      send_op(OP_MUL, 32'hFFFF_FFFF, 32'h0, 32'h0000_0001, 32'h0, 1'b0);
      req_tvalid <= 1'b0;
      @(posedge clock);

      // Random part; one pause until everything has drained
      for (int i = 0; i < 700; i++) begin
         if (i == 350) begin
            req_tvalid <= 1'b0;
            drain();
         end
         send_op(op_type'($urandom_range(0, 3)), pick_value(), pick_value(),
                 ($urandom_range(0, 30) == 0) ? 32'h0 : pick_value(),
                 ($urandom_range(0, 30) == 0) ? 32'h0 : pick_value(), 1'b1);
      end
      req_tvalid <= 1'b0;
      drain();
      repeat (LATENCY + 10) @(posedge clock);

      $display("checked %0d results from %0d transactions", board.checked, sent);
      $display("saturated results %0d, zero divisors %0d", n_ovf, n_dz);
      if (board.errors == 0 && board.pending() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end
endmodule
`default_nettype wire
